### hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// types and codes shared by the timer queue, its timer cells and its ready fifo
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int TIME_W  = 16;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_TABLE_FULL = 2'd1,
        STATUS_READY_MT   = 2'd2,
        STATUS_SPARE      = 2'd3
    } status_t;

    // one timer entry: remaining ticks to expiry (absolute) and task tag
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] remain;
        logic [TAG_W-1:0]  tag;
    } cell_state_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic              insert;
        logic              dec;
        logic              shift_left;
        logic [TIME_W-1:0] want;
        logic [TAG_W-1:0]  tag;
    } cell_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

### hw/rtl/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell
// one timer slot: holds an entry and trades it with its neighbours
// ----------------------------------------------------------------------------
module dtq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::cell_cmd_t  cmd,
    input  dtq_pkg::cell_state_t left_state,
    input  logic                left_ge,
    input  dtq_pkg::cell_state_t right_state,
    output dtq_pkg::cell_state_t state,
    output logic                ge
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [dtq_pkg::TIME_W-1:0] remain_reg;
    logic [dtq_pkg::TIME_W-1:0] remain_next;
    logic [dtq_pkg::TAG_W-1:0]  tag_reg;
    logic [dtq_pkg::TAG_W-1:0]  tag_next;

    // free slot or an entry expiring no earlier than the new one
    assign ge = !valid_reg || (remain_reg >= cmd.want);

    assign state.valid  = valid_reg;
    assign state.remain = remain_reg;
    assign state.tag    = tag_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        remain_next = remain_reg;
        tag_next    = tag_reg;
        if (cmd.insert)
        begin
            if (left_ge)
            begin
                valid_next  = left_state.valid;
                remain_next = left_state.remain;
                tag_next    = left_state.tag;
            end
            else if (ge)
            begin
                valid_next  = 1'b1;
                remain_next = cmd.want;
                tag_next    = cmd.tag;
            end
        end
        else if (cmd.shift_left)
        begin
            valid_next  = right_state.valid;
            remain_next = right_state.remain;
            tag_next    = right_state.tag;
        end
        else if (cmd.dec && valid_reg)
        begin
            remain_next = remain_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        tag_reg    <= tag_next;
    end

endmodule

### hw/rtl/dtq_ready_fifo.sv
// ----------------------------------------------------------------------------
// dtq_ready_fifo
// circular queue of ready task tags, one slot kept free to tell full from empty
// ----------------------------------------------------------------------------
module dtq_ready_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [dtq_pkg::TAG_W-1:0]   push_tag,
    input  logic                        pop,
    output logic [dtq_pkg::TAG_W-1:0]   rd_tag,
    output dtq_pkg::fifo_stat_t         stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [dtq_pkg::TAG_W-1:0] mem [DEPTH];
    logic [dtq_pkg::TAG_W-1:0] rd_tag_reg;
    logic [PW-1:0]             front_reg;
    logic [PW-1:0]             front_next;
    logic [PW-1:0]             rear_reg;
    logic [PW-1:0]             rear_next;
    logic [PW-1:0]             front_inc;
    logic [PW-1:0]             rear_inc;

    assign front_inc = (front_reg == LAST) ? '0 : front_reg + 1'b1;
    assign rear_inc  = (rear_reg == LAST) ? '0 : rear_reg + 1'b1;

    assign stat.empty = (front_reg == rear_reg);
    assign stat.full  = (rear_inc == front_reg);
    assign rd_tag     = rd_tag_reg;

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        if (pop)
        begin
            front_next = front_inc;
        end
        if (push)
        begin
            rear_next = rear_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    // slot ahead of the pointer is the one written / read
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[rear_inc] <= push_tag;
        end
        if (pop)
        begin
            rd_tag_reg <= mem[front_inc];
        end
    end

endmodule

### hw/rtl/delta_timer_queue_with_ready_fifo.sv
// ----------------------------------------------------------------------------
// delta_timer_queue_with_ready_fifo
// sorted timer queue in a row of cells feeding a circular fifo of ready tags
// ----------------------------------------------------------------------------
// Each transaction in gives exactly one result transaction out. Timers live in
// a row of TIMER_SLOTS cells sorted by expiry, each cell holding the ticks left
// until its own expiry rather than a delta, which gives the same answers. On
// an insert every cell compares its expiry with the new delay at once, the
// cells from the insertion point shift one place right and the new entry
// drops in ahead of any equal expiry. A tick decrements every entry in its
// accept cycle, then drains expired entries from the head of the row, one per
// cycle, each drain shifting the whole row left by one; at most TIMER_SLOTS
// timers can expire in one tick. Expired tags are written into the ready fifo,
// which holds READY_DEPTH-1 tags; tags that find it full are dropped and
// counted. A pop passes through ST_POPWAIT because the fifo store is read
// through a registered port. The next transaction is taken once the current
// result has moved into the output register, so the output side may stall
// without losing anything. Out of reset the fifo store needs no clearing:
// only written slots are ever read.
// ----------------------------------------------------------------------------
module delta_timer_queue_with_ready_fifo #(
    parameter int TIMER_SLOTS = 16,
    parameter int READY_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] delay,
    input  logic [15:0] task_tag,
    // result side
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        task_valid,
    output logic [15:0] task_out,
    output logic [4:0]  expired_count,
    output logic [4:0]  dropped_count
);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_DRAIN   = 3'b010,
        ST_POPWAIT = 3'b100
    } state_t;

    localparam logic [dtq_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    state_t state_reg;
    state_t state_next;

    // the row of timer cells
    dtq_pkg::cell_cmd_t   cmd;
    dtq_pkg::cell_state_t cell_st [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] cell_ge;
    logic [TIMER_SLOTS-1:0] occ;

    // ready fifo
    logic                 fifo_push;
    logic                 fifo_pop;
    logic [15:0]          fifo_rd_tag;
    dtq_pkg::fifo_stat_t  fifo_stat;

    // result waiting to enter the output register
    logic        res_pend_reg;
    logic        res_pend_next;
    logic [1:0]  res_status_reg;
    logic [1:0]  res_status_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [15:0] res_task_reg;
    logic [15:0] res_task_next;
    logic [4:0]  exp_cnt_reg;
    logic [4:0]  exp_cnt_next;
    logic [4:0]  drop_cnt_reg;
    logic [4:0]  drop_cnt_next;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_status_reg;
    logic        out_task_valid_reg;
    logic [15:0] out_task_reg;
    logic [4:0]  out_exp_reg;
    logic [4:0]  out_drop_reg;

    logic        accept;
    logic        res_move;
    logic        table_full;
    logic        head_expired;
    logic [15:0] want;

    // ---------------------------------------------------------------- cells
    for (genvar i = 0; i < TIMER_SLOTS; i++)
    begin : g_cell
        dtq_pkg::cell_state_t left_s;
        dtq_pkg::cell_state_t right_s;
        logic                 left_g;

        if (i == 0)
        begin : g_first
            assign left_s = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_s = cell_st[i-1];
            assign left_g = cell_ge[i-1];
        end

        if (i == TIMER_SLOTS - 1)
        begin : g_last
            assign right_s = '0;
        end
        else
        begin : g_inner
            assign right_s = cell_st[i+1];
        end

        dtq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_state  (left_s),
            .left_ge     (left_g),
            .right_state (right_s),
            .state       (cell_st[i]),
            .ge          (cell_ge[i])
        );

        assign occ[i] = cell_st[i].valid;
    end

    // ---------------------------------------------------------------- fifo
    dtq_ready_fifo #(
        .DEPTH (READY_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_tag (cell_st[0].tag),
        .pop      (fifo_pop),
        .rd_tag   (fifo_rd_tag),
        .stat     (fifo_stat)
    );

    // ---------------------------------------------------------------- control
    assign in_stall     = (state_reg != ST_IDLE) || res_pend_reg;
    assign accept       = in_valid && !in_stall;
    assign res_move     = res_pend_reg && (!out_valid_reg || !out_stall);
    assign table_full   = occ[TIMER_SLOTS-1];
    assign head_expired = cell_st[0].valid && (cell_st[0].remain == '0);
    // a zero delay would never fire, so it counts as one tick
    assign want         = (delay == '0) ? 16'd1 : delay;

    always_comb
    begin
        state_next      = state_reg;
        res_pend_next   = res_pend_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_task_next   = res_task_reg;
        exp_cnt_next    = exp_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        cmd.insert      = 1'b0;
        cmd.dec         = 1'b0;
        cmd.shift_left  = 1'b0;
        cmd.want        = want;
        cmd.tag         = task_tag;
        fifo_push       = 1'b0;
        fifo_pop        = 1'b0;

        if (res_move)
        begin
            res_pend_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = dtq_pkg::STATUS_OK;
                    res_valid_next  = 1'b0;
                    res_task_next   = '0;
                    exp_cnt_next    = '0;
                    drop_cnt_next   = '0;
                    case (op)
                        dtq_pkg::OP_INSERT:
                        begin
                            res_pend_next = 1'b1;
                            if (table_full)
                            begin
                                res_status_next = dtq_pkg::STATUS_TABLE_FULL;
                            end
                            else
                            begin
                                cmd.insert = 1'b1;
                            end
                        end
                        dtq_pkg::OP_TICK:
                        begin
                            // head only counts down while nonzero
                            cmd.dec    = cell_st[0].valid && (cell_st[0].remain != '0);
                            state_next = ST_DRAIN;
                        end
                        dtq_pkg::OP_POP:
                        begin
                            if (fifo_stat.empty)
                            begin
                                res_status_next = dtq_pkg::STATUS_READY_MT;
                                res_pend_next   = 1'b1;
                            end
                            else
                            begin
                                fifo_pop   = 1'b1;
                                state_next = ST_POPWAIT;
                            end
                        end
                        default:
                        begin
                            res_pend_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (head_expired)
                begin
                    cmd.shift_left = 1'b1;
                    if (fifo_stat.full)
                    begin
                        if (drop_cnt_reg != COUNT_MAX)
                        begin
                            drop_cnt_next = drop_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        fifo_push = 1'b1;
                    end
                    if (exp_cnt_reg != COUNT_MAX)
                    begin
                        exp_cnt_next = exp_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    res_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_POPWAIT:
            begin
                res_valid_next = 1'b1;
                res_task_next  = fifo_rd_tag;
                res_pend_next  = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            res_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_pend_reg <= res_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_task_reg   <= res_task_next;
        exp_cnt_reg    <= exp_cnt_next;
        drop_cnt_reg   <= drop_cnt_next;
    end

    // ---------------------------------------------------------------- output
    always_comb
    begin
        if (res_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_move)
        begin
            out_status_reg     <= res_status_reg;
            out_task_valid_reg <= res_valid_reg;
            out_task_reg       <= res_task_reg;
            out_exp_reg        <= exp_cnt_reg;
            out_drop_reg       <= drop_cnt_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign task_valid    = out_task_valid_reg;
    assign task_out      = out_task_reg;
    assign expired_count = out_exp_reg;
    assign dropped_count = out_drop_reg;

    // ---------------------------------------------------------------- checks
    // occupied cells always form an unbroken run from the head
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (occ & (occ + 1'b1)) == '0)
        else $error("timer cells not packed towards the head");

    // between transactions the head entry has not yet expired
    a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && occ[0] |-> (cell_st[0].remain != '0))
        else $error("expired entry left at the head of the row");

    // a pending result only exists once the sequencer is back at rest
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_pend_reg |-> (state_reg == ST_IDLE))
        else $error("result pending while sequencer busy");

    // drops are a subset of expiries
    a_drop_le_exp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dropped_count <= expired_count))
        else $error("more drops than expiries reported");

endmodule

### bench/tb_delta_timer_queue_with_ready_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delta_timer_queue_with_ready_fifo
// self-checking bench for the delta timer queue and its ready fifo
// ----------------------------------------------------------------------------
// Requests are driven one transaction at a time through the valid/stall port.
// At each accepted request a local copy of the timer list and the ready fifo
// works out the one result that the block owes, and queues it. A checking
// process compares every accepted result against the oldest queued one.
// Directed corners come first, then phases of weighted random traffic, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_delta_timer_queue_with_ready_fifo;

    localparam int TIMER_SLOTS   = 16;
    localparam int READY_DEPTH   = 16;
    localparam int DRAIN_LIMIT   = 5000;   // cycles allowed for results to clear
    localparam int SETTLE_CYCLES = 40;
    localparam int FAR_EXPIRY    = 1000;   // timers beyond this count as parked

    // one result transaction as the block should present it
    typedef struct {
        dtq_pkg::status_t status;
        logic             task_valid;
        logic [15:0]      task_out;
        logic [4:0]       expired;
        logic [4:0]       dropped;
    } queue_result_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        clk = 1'b1;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = dtq_pkg::OP_NONE;
    logic [15:0] delay = '0;
    logic [15:0] task_tag = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        task_valid;
    logic [15:0] task_out;
    logic [4:0]  expired_count;
    logic [4:0]  dropped_count;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    delta_timer_queue_with_ready_fifo #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .READY_DEPTH (READY_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .delay         (delay),
        .task_tag      (task_tag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .task_valid    (task_valid),
        .task_out      (task_out),
        .expired_count (expired_count),
        .dropped_count (dropped_count)
    );

    // ------------------------------------------------------------------------
    // local copy of the timer list (delta form) and the ready fifo
    // ------------------------------------------------------------------------
    logic [15:0]   timer_gap [TIMER_SLOTS];   // ticks after the entry ahead
    logic [15:0]   timer_id [TIMER_SLOTS];
    int            timers_held;
    logic [15:0]   ready_tags [READY_DEPTH];
    int            ready_head;
    int            ready_tail;

    queue_result_t awaited_results[$];
    queue_result_t oldest_result;

    // run bookkeeping
    int  mismatches;
    int  requests_sent;
    int  results_checked;
    int  refused_inserts;
    int  empty_pops;
    int  timers_fired;
    int  tags_dropped;
    int  stall_left;
    bit  quiet;          // set for stretches with no gaps and no stalls

    // ------------------------------------------------------------------------
    // timer queue behaviour: applies one request, returns the result it owes
    // ------------------------------------------------------------------------
    function automatic queue_result_t timer_queue_step(dtq_pkg::op_t req_op,
                                                       logic [15:0] req_delay,
                                                       logic [15:0] req_tag);
        queue_result_t r;
        int want;
        int sum;
        int prior;
        int pos;
        int mine;
        int fired;
        int lost;
        int nxt;

        r = '{dtq_pkg::STATUS_OK, 1'b0, 16'd0, 5'd0, 5'd0};
        case (req_op)
            dtq_pkg::OP_INSERT:
            begin
                // a zero delay would never fire, so it counts as one tick
                want = (req_delay == 16'd0) ? 1 : int'(req_delay);
                if (timers_held >= TIMER_SLOTS)
                begin
                    r.status = dtq_pkg::STATUS_TABLE_FULL;
                    refused_inserts++;
                end
                else
                begin
                    sum   = 0;
                    prior = 0;
                    pos   = timers_held;
                    // first entry expiring no earlier than the new one; equal expiry
                    // puts the new entry ahead
                    for (int i = 0; i < timers_held; i++)
                    begin
                        prior = sum;
                        sum += timer_gap[i];
                        if (sum >= want)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos == timers_held)
                        timer_gap[pos] = 16'(want - sum);
                    else
                    begin
                        mine = want - prior;
                        for (int k = timers_held; k > pos; k--)
                        begin
                            timer_gap[k] = timer_gap[k-1];
                            timer_id[k]  = timer_id[k-1];
                        end
                        timer_gap[pos]   = 16'(mine);
                        timer_gap[pos+1] = 16'(timer_gap[pos+1] - mine);
                    end
                    timer_id[pos] = req_tag;
                    timers_held++;
                end
            end
            dtq_pkg::OP_TICK:
            begin
                fired = 0;
                lost  = 0;
                if (timers_held != 0)
                begin
                    if (timer_gap[0] != 16'd0)
                        timer_gap[0] = timer_gap[0] - 16'd1;
                    // leading zero entries move to the fifo in list order, lost if it is full
                    while (fired < timers_held && timer_gap[fired] == 16'd0)
                    begin
                        nxt = (ready_tail + 1) % READY_DEPTH;
                        if (nxt == ready_head)
                            lost++;
                        else
                        begin
                            ready_tail = nxt;
                            ready_tags[ready_tail] = timer_id[fired];
                        end
                        fired++;
                    end
                    for (int k = fired; k < timers_held; k++)
                    begin
                        timer_gap[k-fired] = timer_gap[k];
                        timer_id[k-fired]  = timer_id[k];
                    end
                    timers_held -= fired;
                end
                r.expired = (fired > 31) ? 5'd31 : fired[4:0];
                r.dropped = (lost > 31) ? 5'd31 : lost[4:0];
                timers_fired += fired;
                tags_dropped += lost;
            end
            dtq_pkg::OP_POP:
            begin
                if (ready_tail == ready_head)
                begin
                    r.status = dtq_pkg::STATUS_READY_MT;
                    empty_pops++;
                end
                else
                begin
                    ready_head   = (ready_head + 1) % READY_DEPTH;
                    r.task_out   = ready_tags[ready_head];
                    r.task_valid = 1'b1;
                end
            end
            default:
            begin
                // unused code: nothing changes, all fields zero
            end
        endcase
        return r;
    endfunction

    // timers parked far in the future; kept few so they do not clog the table
    function automatic int far_timers();
        int total;
        int n;

        total = 0;
        n     = 0;
        for (int i = 0; i < timers_held; i++)
        begin
            total += timer_gap[i];
            if (total > FAR_EXPIRY)
                n++;
        end
        return n;
    endfunction

    // gap or stall length: mostly short, a few long
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_delay();
        int r;

        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'd0;
        if (r < 70)
            return 16'($urandom_range(1, 4));
        if (r < 95)
            return 16'($urandom_range(5, 40));
        if (r < 97 && far_timers() < 3)
            return 16'($urandom);
        return 16'($urandom_range(41, 300));
    endfunction

    function automatic dtq_pkg::op_t pick_op(int w_insert, int w_tick, int w_pop);
        int r;

        if ($urandom_range(0, 99) < 3)
            return dtq_pkg::OP_NONE;
        r = $urandom_range(0, w_insert + w_tick + w_pop - 1);
        if (r < w_insert)
            return dtq_pkg::OP_INSERT;
        if (r < w_insert + w_tick)
            return dtq_pkg::OP_TICK;
        return dtq_pkg::OP_POP;
    endfunction

    // ------------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // request side: one transaction, then an optional gap
    // called at a rising edge, returns at a rising edge
    // ------------------------------------------------------------------------
    task automatic send_request(dtq_pkg::op_t req_op, logic [15:0] req_delay,
                                logic [15:0] req_tag);
        int gap;

        in_valid <= 1'b1;
        op       <= req_op;
        delay    <= req_delay;
        task_tag <= req_tag;
        // payload holds still while the block stalls
        do
            @(posedge clk);
        while (in_stall);
        awaited_results.push_back(timer_queue_step(req_op, req_delay, req_tag));
        requests_sent++;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the request side until every owed result has come back
    task automatic wait_for_results();
        int waited;

        waited = 0;
        in_valid <= 1'b0;
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (awaited_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
            awaited_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: check each accepted transaction, then choose the next stall
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("unexpected result st=%0d tv=%0d tag=%h",
                                              status, task_valid, task_out));
                else
                begin
                    oldest_result = awaited_results.pop_front();
                    results_checked++;
                    if (status !== oldest_result.status ||
                        task_valid !== oldest_result.task_valid ||
                        task_out !== oldest_result.task_out ||
                        expired_count !== oldest_result.expired ||
                        dropped_count !== oldest_result.dropped)
                        report_mismatch($sformatf(
                            {"result %0d got st=%0d tv=%0d tag=%h exp=%0d drop=%0d, ",
                             "want st=%0d tv=%0d tag=%h exp=%0d drop=%0d"},
                            results_checked, status, task_valid, task_out, expired_count,
                            dropped_count, oldest_result.status, oldest_result.task_valid,
                            oldest_result.task_out, oldest_result.expired,
                            oldest_result.dropped));
                end
            end
            // stall pattern
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty fifo pop, tick with no timers, unused code
    task automatic test_empty_queue_corners();
        send_request(dtq_pkg::OP_POP, 16'd0, 16'd0);
        send_request(dtq_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        send_request(dtq_pkg::OP_NONE, 16'hFFFF, 16'hFFFF);
    endtask

    // fill the timer table, get refused, expire into the fifo until it overflows
    task automatic test_table_and_ready_overflow();
        send_request(dtq_pkg::OP_INSERT, 16'd0, 16'hFFFF);    // zero delay fires first tick
        send_request(dtq_pkg::OP_INSERT, 16'd2, 16'hAAAA);
        send_request(dtq_pkg::OP_INSERT, 16'd2, 16'h5555);    // equal expiry, ahead of 0xaaaa
        send_request(dtq_pkg::OP_INSERT, 16'hFFFF, 16'h0000); // longest delay, stays parked
        for (int i = 0; i < TIMER_SLOTS - 4; i++)
            send_request(dtq_pkg::OP_INSERT, 16'd1, 16'(16'h1000 + i));
        send_request(dtq_pkg::OP_INSERT, 16'd5, 16'h0BAD);    // table full, refused
        send_request(dtq_pkg::OP_TICK, 16'd0, 16'd0);         // thirteen fire together
        send_request(dtq_pkg::OP_TICK, 16'd0, 16'd0);         // fifo reaches its fifteen
        send_request(dtq_pkg::OP_INSERT, 16'd0, 16'h7777);
        send_request(dtq_pkg::OP_TICK, 16'd0, 16'd0);         // fifo full, this one dropped
        send_request(dtq_pkg::OP_POP, 16'd0, 16'd0);
        send_request(dtq_pkg::OP_POP, 16'd0, 16'd0);
    endtask

    // weighted random traffic; unused codes do not count toward the total
    task automatic test_random_traffic(int count, int w_insert, int w_tick, int w_pop,
                                       bit no_idle);
        int done;
        dtq_pkg::op_t pick;

        quiet = no_idle;
        done  = 0;
        while (done < count)
        begin
            pick = pick_op(w_insert, w_tick, w_pop);
            send_request(pick, pick_delay(), 16'($urandom));
            if (pick != dtq_pkg::OP_NONE)
                done++;
        end
        wait_for_results();
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mismatches      = 0;
        requests_sent   = 0;
        results_checked = 0;
        refused_inserts = 0;
        empty_pops      = 0;
        timers_fired    = 0;
        tags_dropped    = 0;
        stall_left      = 0;
        quiet           = 1'b0;
        timers_held     = 0;
        ready_head      = 0;
        ready_tail      = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue_corners();
        test_table_and_ready_overflow();
        wait_for_results();

        test_random_traffic(250, 35, 30, 30, 1'b0);   // balanced
        test_random_traffic(250, 55, 25, 15, 1'b0);   // table fills, inserts refused
        test_random_traffic(250, 35, 50, 10, 1'b0);   // fifo fills, tags dropped
        test_random_traffic(250, 25, 25, 50, 1'b0);   // fifo drains, empty pops
        test_random_traffic(200, 35, 30, 30, 1'b1);   // back to back, no stalls
        test_random_traffic(250, 45, 40, 15, 1'b0);
        test_random_traffic(200, 30, 30, 40, 1'b1);

        $display("covered %0d transactions, %0d results checked, %0d mismatches",
                 requests_sent, results_checked, mismatches);
        $display("timers fired %0d, tags dropped %0d, inserts refused %0d, empty pops %0d",
                 timers_fired, tags_dropped, refused_inserts, empty_pops);
        if (mismatches == 0)
            $display("tb_delta_timer_queue_with_ready_fifo OK");
        else
            $display("tb_delta_timer_queue_with_ready_fifo NOT OK");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #25_000_000;
        $display("tb_delta_timer_queue_with_ready_fifo NOT OK");
        $finish;
    end

endmodule
